[hdl/srcd_pkg.sv]
// ----------------------------------------------------------------------------
// Shift register chain driver package
// Sizes, register indexes, action codes and status codes shared by the block.
// ----------------------------------------------------------------------------
package srcd_pkg;

  localparam int MAX_CHAIN_BYTES = 8;
  localparam int BYTE_W          = 8;
  localparam int IDX_W           = (MAX_CHAIN_BYTES > 1) ? $clog2(MAX_CHAIN_BYTES) : 1;
  localparam int LEN_W           = 4;
  localparam int BIT_IDX_W       = 6;
  localparam int BIT_CNT_W       = 3;
  localparam int STATUS_W        = 2;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;
  localparam int REG_IDX_W       = 1;

  localparam logic [REG_IDX_W-1:0] REG_CHAIN_LENGTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_LATCH_ENABLE = 1'b1;

  localparam logic ACTION_PUSH = 1'b0;
  localparam logic ACTION_BIT  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_CHAIN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

  localparam logic [LEN_W-1:0]     MAX_LEN  = LEN_W'(MAX_CHAIN_BYTES);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BYTE_W - 1);

  typedef struct packed {
    logic [LEN_W-1:0] chain_length;
    logic             latch_enable;
    logic             clear;
  } cfg_t;

endpackage

[hdl/srcd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/srcd_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for chain length and latch enable.
// ----------------------------------------------------------------------------
module srcd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srcd_pkg::PADDR_W-1:0]  paddr,
  input  logic [srcd_pkg::PDATA_W-1:0]  pwdata,
  output logic [srcd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output srcd_pkg::cfg_t                cfg
);
  import srcd_pkg::*;

  logic [LEN_W-1:0]     chain_length;
  logic                 latch_enable;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length <= LEN_W'(2);
      latch_enable <= 1'b1;
    end else if (wr) begin
      case (reg_idx)
        REG_CHAIN_LENGTH: chain_length <= pwdata[LEN_W-1:0];
        REG_LATCH_ENABLE: latch_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHAIN_LENGTH: prdata = {{(PDATA_W-LEN_W){1'b0}}, chain_length};
      REG_LATCH_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, latch_enable};
      default:          prdata = '0;
    endcase
  end

  assign cfg.chain_length = chain_length;
  assign cfg.latch_enable = latch_enable;
  assign cfg.clear        = wr && (reg_idx == REG_CHAIN_LENGTH);

endmodule

[hdl/shift_register_chain_driver.sv]
// ----------------------------------------------------------------------------
// Shift register chain driver
// Order: an accepted input word passes through FETCH and LOAD before the first
// bit word; an error status word is presented in the cycle after acceptance.
// Each chain byte is read, updated and written back in RAM, then shifted out
// as out_ready allows; no new word is accepted until the previous one is done.
// Reset: the shadow image reads as all zeros, chain length 2, latch enabled.
// ----------------------------------------------------------------------------
module shift_register_chain_driver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srcd_pkg::PADDR_W-1:0]    paddr,
  input  logic [srcd_pkg::PDATA_W-1:0]    pwdata,
  output logic [srcd_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic [srcd_pkg::BYTE_W-1:0]     byte_value,
  input  logic [srcd_pkg::BIT_IDX_W-1:0]  bit_index,
  input  logic                            bit_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            serial_bit,
  output logic                            latch_pulse,
  output logic                            last,
  output logic [srcd_pkg::STATUS_W-1:0]   status
);
  import srcd_pkg::*;

  typedef enum logic [1:0] {IDLE, FETCH, LOAD, SHIFT} state_t;

  cfg_t                 cfg;
  state_t               state;
  logic [IDX_W-1:0]     byte_idx;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [BIT_CNT_W-1:0] bit_nxt;
  logic [BYTE_W-1:0]    carry;
  logic [BYTE_W-1:0]    sreg;
  logic                 op_action;
  logic [IDX_W-1:0]     op_pos;
  logic [2:0]           op_bit;
  logic                 op_value;
  logic [MAX_CHAIN_BYTES-1:0] valid;
  logic                 rd_valid;
  logic [BYTE_W-1:0]    rdata;
  logic [BYTE_W-1:0]    old_byte;
  logic [BYTE_W-1:0]    mod_byte;
  logic [BYTE_W-1:0]    new_byte;
  logic [LEN_W-1:0]     len;
  logic [IDX_W-1:0]     len_m1;
  logic                 last_byte;
  logic                 in_acc;
  logic                 out_acc;
  logic                 ram_we;

  srcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign len       = (cfg.chain_length > MAX_LEN) ? MAX_LEN : cfg.chain_length;
  assign len_m1    = IDX_W'(len - LEN_W'(1));
  assign last_byte = (byte_idx == len_m1);
  assign in_ready  = (state == IDLE) && !out_valid;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign bit_nxt   = bit_cnt + BIT_CNT_W'(1);

  // A byte never written since reset or resize reads as zero.
  assign old_byte = rd_valid ? rdata : '0;

  always_comb begin
    mod_byte         = old_byte;
    mod_byte[op_bit] = op_value;
    if (op_action == ACTION_PUSH) begin
      new_byte = carry;
    end else if (byte_idx == op_pos) begin
      new_byte = mod_byte;
    end else begin
      new_byte = old_byte;
    end
  end

  assign ram_we = (state == LOAD);

  srcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_CHAIN_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_idx),
    .wdata (new_byte),
    .raddr (byte_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[byte_idx] <= 1'b1;
    end
    rd_valid <= valid[byte_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      byte_idx  <= '0;
      bit_cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (out_acc) begin
            out_valid <= 1'b0;
          end
          if (in_acc) begin
            op_action <= action;
            op_pos    <= bit_index[3 +: IDX_W];
            op_bit    <= bit_index[2:0];
            op_value  <= bit_value;
            carry     <= byte_value;
            byte_idx  <= '0;
            if (len == '0) begin
              out_valid   <= 1'b1;
              serial_bit  <= 1'b0;
              latch_pulse <= 1'b0;
              last        <= 1'b1;
              status      <= STATUS_NO_CHAIN;
            end else if (action == ACTION_BIT &&
                         {1'b0, bit_index} >= {len, 3'b000}) begin
              out_valid   <= 1'b1;
              serial_bit  <= 1'b0;
              latch_pulse <= 1'b0;
              last        <= 1'b1;
              status      <= STATUS_RANGE;
            end else begin
              state <= FETCH;
            end
          end
        end
        FETCH: begin
          state <= LOAD;
        end
        LOAD: begin
          carry       <= old_byte;
          sreg        <= new_byte;
          bit_cnt     <= '0;
          out_valid   <= 1'b1;
          serial_bit  <= new_byte[0];
          last        <= 1'b0;
          latch_pulse <= 1'b0;
          status      <= STATUS_OK;
          state       <= SHIFT;
        end
        SHIFT: begin
          if (out_acc) begin
            if (bit_cnt == LAST_BIT) begin
              out_valid <= 1'b0;
              if (last_byte) begin
                state <= IDLE;
              end else begin
                byte_idx <= byte_idx + IDX_W'(1);
                state    <= FETCH;
              end
            end else begin
              bit_cnt     <= bit_nxt;
              serial_bit  <= sreg[bit_nxt];
              last        <= (bit_nxt == LAST_BIT) && last_byte;
              latch_pulse <= (bit_nxt == LAST_BIT) && last_byte && cfg.latch_enable;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last) |=> (state == IDLE))
    else $error("final word did not return the driver to idle");

  a_latch_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && latch_pulse) |-> last)
    else $error("latch pulse on a word that is not final");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (last && !serial_bit && !latch_pulse))
    else $error("malformed status word");

  a_index_in_chain: assert property (@(posedge clk) disable iff (rst)
    (state == LOAD) |-> (byte_idx <= len_m1))
    else $error("byte index beyond the chain");

endmodule
